// ===== rtl/svd_pkg.sv =====
// Shared widths, codes, types and helpers for the SVPWM sector/duty block.
`timescale 1ns / 1ps

package svd_pkg;

  localparam int VIN_W      = 16;  // alpha/beta input width
  localparam int PER_W      = 15;  // carrier period register width
  localparam int SCALE_W    = 16;  // alpha scale register width
  localparam int DT_W       = 10;  // dead time register width
  localparam int CMP_W      = 16;  // compare output width
  localparam int SEC_W      = 3;   // sector code width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int PROD_W = 33;      // scaled alpha/beta and X, Y, Z
  localparam int SUM_W  = 35;      // sums of two of X, Y, Z with headroom

  localparam logic [4:0] SH_HALF = 5'd1;   // divide by 2
  localparam logic [4:0] SH_ONE  = 5'd17;  // divide by 131072
  localparam logic [4:0] SH_SUM  = 5'd18;  // divide by 262144

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_SCALE  = 2'd1,
    CFG_DEAD   = 2'd2
  } cfg_idx_e;

  typedef enum logic [SEC_W-1:0] {
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5,
    SEC_6 = 3'd6
  } sector_e;

  // Sector decision handed from the sector stage to the compare stage.
  typedef struct packed {
    sector_e                 sector;
    logic signed [SUM_W-1:0] sum;    // numerator of the first phase offset
    logic [CMP_W-1:0]        step1;  // signed offset to the second phase
    logic [CMP_W-1:0]        step2;  // signed offset to the third phase
  } sec_t;

  // Arithmetic shift right that truncates toward zero, like C division.
  function automatic logic signed [SUM_W-1:0] trunc_shr(
    input logic signed [SUM_W-1:0] v,
    input logic [4:0]              sh
  );
    logic signed [SUM_W-1:0] bias;
    bias = v[SUM_W-1] ? ((SUM_W'(1) << sh) - SUM_W'(1)) : '0;
    return (v + bias) >>> sh;
  endfunction

endpackage

// ===== rtl/svd_mult.sv =====
// Input register and the two scaling multipliers (alpha by scale, beta by -2*period).
`timescale 1ns / 1ps

module svd_mult (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_vld_i,
  input  logic signed [svd_pkg::VIN_W-1:0]    v_alpha_i,
  input  logic signed [svd_pkg::VIN_W-1:0]    v_beta_i,
  input  logic [svd_pkg::PER_W-1:0]           pwm_period_i,
  input  logic [svd_pkg::SCALE_W-1:0]         alpha_scale_i,
  output logic                                prod_vld_o,
  output logic signed [svd_pkg::PROD_W-1:0]   ua_o,
  output logic signed [svd_pkg::PROD_W-1:0]   ub_o
);
  import svd_pkg::*;

  logic                        in_vld_q;
  logic signed [VIN_W-1:0]     va_q, vb_q;
  logic signed [PROD_W-1:0]    ua_d, ub_d, ua_q, ub_q;
  logic signed [2*VIN_W-1:0]   pb;
  logic                        prod_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      in_vld_q   <= in_vld_i;
      prod_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q <= v_alpha_i;
    vb_q <= v_beta_i;
    ua_q <= ua_d;
    ub_q <= ub_d;
  end

  always_comb begin
    ua_d = va_q * $signed({1'b0, alpha_scale_i});
    pb   = vb_q * $signed({1'b0, pwm_period_i});
    ub_d = -(PROD_W'(pb) <<< 1);
  end

  assign prod_vld_o = prod_vld_q;
  assign ua_o       = ua_q;
  assign ub_o       = ub_q;

endmodule

// ===== rtl/svd_sector.sv =====
// X/Y/Z formation and six-sector decision with the scaled offsets.
`timescale 1ns / 1ps

module svd_sector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               prod_vld_i,
  input  logic signed [svd_pkg::PROD_W-1:0]  ua_i,
  input  logic signed [svd_pkg::PROD_W-1:0]  ub_i,
  output logic                               sec_vld_o,
  output svd_pkg::sec_t                      sec_o
);
  import svd_pkg::*;

  logic                     xyz_vld_q, sec_vld_q;
  logic signed [PROD_W-1:0] x_q, y_q, z_q;
  logic signed [PROD_W-1:0] y_d, z_d;
  sec_t                     sec_d, sec_q;

  logic signed [SUM_W-1:0]  xs, ys, zs;
  logic signed [SUM_W-1:0]  xs_sh, ys_sh, zs_sh;
  logic [CMP_W-1:0]         xo, yo, zo;
  logic                     y_neg, z_neg, x_nonpos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xyz_vld_q <= 1'b0;
      sec_vld_q <= 1'b0;
    end else begin
      xyz_vld_q <= prod_vld_i;
      sec_vld_q <= xyz_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= ub_i;
    y_q   <= y_d;
    z_q   <= z_d;
    sec_q <= sec_d;
  end

  // Halve the sum and difference of the scaled components.
  always_comb begin
    y_d = PROD_W'(trunc_shr(SUM_W'(ub_i) + SUM_W'(ua_i), SH_HALF));
    z_d = PROD_W'(trunc_shr(SUM_W'(ub_i) - SUM_W'(ua_i), SH_HALF));
  end

  always_comb begin
    xs       = SUM_W'(x_q);
    ys       = SUM_W'(y_q);
    zs       = SUM_W'(z_q);
    xs_sh    = trunc_shr(xs, SH_ONE);
    ys_sh    = trunc_shr(ys, SH_ONE);
    zs_sh    = trunc_shr(zs, SH_ONE);
    xo       = xs_sh[CMP_W-1:0];
    yo       = ys_sh[CMP_W-1:0];
    zo       = zs_sh[CMP_W-1:0];
    y_neg    = y_q[PROD_W-1];
    z_neg    = z_q[PROD_W-1];
    x_nonpos = x_q[PROD_W-1] || (x_q == '0);

    if (y_neg) begin
      if (z_neg) begin
        sec_d.sector = SEC_5;
        sec_d.sum    = ys + zs;
        sec_d.step1  = -yo;
        sec_d.step2  = -zo;
      end else if (x_nonpos) begin
        sec_d.sector = SEC_4;
        sec_d.sum    = xs - zs;
        sec_d.step1  = -xo;
        sec_d.step2  = zo;
      end else begin
        sec_d.sector = SEC_3;
        sec_d.sum    = ys - xs;
        sec_d.step1  = xo;
        sec_d.step2  = -yo;
      end
    end else begin
      if (!z_neg) begin
        sec_d.sector = SEC_2;
        sec_d.sum    = -(ys + zs);
        sec_d.step1  = zo;
        sec_d.step2  = yo;
      end else if (x_nonpos) begin
        sec_d.sector = SEC_6;
        sec_d.sum    = xs - ys;
        sec_d.step1  = yo;
        sec_d.step2  = -xo;
      end else begin
        sec_d.sector = SEC_1;
        sec_d.sum    = zs - xs;
        sec_d.step1  = -zo;
        sec_d.step2  = xo;
      end
    end
  end

  assign sec_vld_o = sec_vld_q;
  assign sec_o     = sec_q;

  // Lower half-plane sectors follow the sign of Y.
  a_sector_half : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> ((sec_q.sector == SEC_3 || sec_q.sector == SEC_4 ||
                    sec_q.sector == SEC_5) == $past(y_q[PROD_W-1])))
    else $error("sector half-plane does not match sign of Y");

endmodule

// ===== rtl/svd_cmp.sv =====
// Phase time build-up, phase routing by sector, and dead-time output register.
`timescale 1ns / 1ps

module svd_cmp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sec_vld_i,
  input  svd_pkg::sec_t                 sec_i,
  input  logic [svd_pkg::PER_W-1:0]     pwm_period_i,
  input  logic [svd_pkg::DT_W-1:0]      dead_time_i,
  output logic                          done_o,
  output logic [svd_pkg::SEC_W-1:0]     sector_o,
  output logic [svd_pkg::CMP_W-1:0]     cmp_a_high_o,
  output logic [svd_pkg::CMP_W-1:0]     cmp_a_low_o,
  output logic [svd_pkg::CMP_W-1:0]     cmp_b_high_o,
  output logic [svd_pkg::CMP_W-1:0]     cmp_b_low_o,
  output logic [svd_pkg::CMP_W-1:0]     cmp_c_high_o,
  output logic [svd_pkg::CMP_W-1:0]     cmp_c_low_o
);
  import svd_pkg::*;

  logic                  t_vld_q, out_vld_q;
  sector_e               t_sec_q, out_sec_q;
  logic [CMP_W-1:0]      ta_d, tb_d, tc_d, ta_q, tb_q, tc_q;
  logic [CMP_W-1:0]      quarter, t1, t2, t3, dt;
  logic signed [SUM_W-1:0] ofs;
  logic [CMP_W-1:0]      ah_q, al_q, bh_q, bl_q, ch_q, cl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      t_vld_q   <= sec_vld_i;
      out_vld_q <= t_vld_q;
    end
  end

  // Chain the three phase times; only the low 16 bits are ever kept.
  always_comb begin
    quarter = CMP_W'(pwm_period_i >> 2);
    ofs     = trunc_shr(sec_i.sum, SH_SUM);
    t1      = quarter + ofs[CMP_W-1:0];
    t2      = t1 + sec_i.step1;
    t3      = t2 + sec_i.step2;
    case (sec_i.sector)
      SEC_1: begin ta_d = t1; tb_d = t2; tc_d = t3; end
      SEC_2: begin tb_d = t1; ta_d = t2; tc_d = t3; end
      SEC_3: begin tb_d = t1; tc_d = t2; ta_d = t3; end
      SEC_4: begin tc_d = t1; tb_d = t2; ta_d = t3; end
      SEC_5: begin tc_d = t1; ta_d = t2; tb_d = t3; end
      SEC_6: begin ta_d = t1; tc_d = t2; tb_d = t3; end
      default: begin ta_d = t1; tb_d = t2; tc_d = t3; end
    endcase
  end

  assign dt = CMP_W'(dead_time_i);

  always_ff @(posedge clk_i) begin
    t_sec_q   <= sec_i.sector;
    ta_q      <= ta_d;
    tb_q      <= tb_d;
    tc_q      <= tc_d;
    out_sec_q <= t_sec_q;
    ah_q      <= ta_q + dt;
    al_q      <= ta_q - dt;
    bh_q      <= tb_q + dt;
    bl_q      <= tb_q - dt;
    ch_q      <= tc_q + dt;
    cl_q      <= tc_q - dt;
  end

  assign done_o       = out_vld_q;
  assign sector_o     = out_sec_q;
  assign cmp_a_high_o = ah_q;
  assign cmp_a_low_o  = al_q;
  assign cmp_b_high_o = bh_q;
  assign cmp_b_low_o  = bl_q;
  assign cmp_c_high_o = ch_q;
  assign cmp_c_low_o  = cl_q;

  // High and low compares of each phase sit twice the dead time apart; phases A and C are checked here.
  a_dead_band : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((CMP_W'(ah_q - al_q) == CMP_W'({$past(dead_time_i), 1'b0})) &&
                   (CMP_W'(ch_q - cl_q) == CMP_W'({$past(dead_time_i), 1'b0}))))
    else $error("dead band between high and low compare is wrong");

endmodule

// ===== rtl/svpwm_sector_duty.sv =====
// Top level of the space-vector PWM sector and compare generator.
`timescale 1ns / 1ps

// Usage
//   Input channel: drive v_alpha_i / v_beta_i with start_i high for one
//   cycle; the transaction is taken at that rising edge (busy_o is always
//   low, so every start is taken). A new transaction may follow in every
//   cycle.
//   Result channel: done_o is high for exactly one cycle with sector_o and
//   the six compare values; the receiver must take them in that cycle, it
//   cannot stall the block, and nothing here ever needs to hold back.
//   Pipeline: the inputs are loaded into the input register at the accepting
//   edge, then pass the multiply, X/Y/Z, sector, phase-time and output
//   registers; done_o rises with the output register.
//   Throughput: one transaction per clock, set by the fully pipelined
//   datapath with one multiplier pair in the multiply stage.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 period, 1 alpha scale, 2 dead time); index 3 is dropped. Write only
//   while no transaction is in flight.
//   Reset: rst_ni clears the pipeline valid bits and loads the register
//   defaults: period 4800, alpha scale 16627, dead time 30.
module svpwm_sector_duty (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [svd_pkg::VIN_W-1:0]    v_alpha_i,
  input  logic signed [svd_pkg::VIN_W-1:0]    v_beta_i,
  input  logic                                cfg_we_i,
  input  logic [svd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [svd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output logic                                done_o,
  output logic [svd_pkg::SEC_W-1:0]           sector_o,
  output logic [svd_pkg::CMP_W-1:0]           cmp_a_high_o,
  output logic [svd_pkg::CMP_W-1:0]           cmp_a_low_o,
  output logic [svd_pkg::CMP_W-1:0]           cmp_b_high_o,
  output logic [svd_pkg::CMP_W-1:0]           cmp_b_low_o,
  output logic [svd_pkg::CMP_W-1:0]           cmp_c_high_o,
  output logic [svd_pkg::CMP_W-1:0]           cmp_c_low_o
);
  import svd_pkg::*;

  logic [PER_W-1:0]          period_q;
  logic [SCALE_W-1:0]        scale_q;
  logic [DT_W-1:0]           dead_q;

  logic                      accept;
  logic                      prod_vld;
  logic signed [PROD_W-1:0]  ua, ub;
  logic                      sec_vld;
  sec_t                      sec;

  // The pipeline never stalls: take a transaction on every start.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Configuration registers; an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PER_W'(4800);
      scale_q  <= SCALE_W'(16627);
      dead_q   <= DT_W'(30);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD: period_q <= cfg_wdata_i[PER_W-1:0];
        CFG_SCALE:  scale_q  <= cfg_wdata_i[SCALE_W-1:0];
        CFG_DEAD:   dead_q   <= cfg_wdata_i[DT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register the inputs and scale alpha and beta.
  svd_mult u_mult (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_vld_i      (accept),
    .v_alpha_i     (v_alpha_i),
    .v_beta_i      (v_beta_i),
    .pwm_period_i  (period_q),
    .alpha_scale_i (scale_q),
    .prod_vld_o    (prod_vld),
    .ua_o          (ua),
    .ub_o          (ub)
  );

  // Form X, Y, Z and pick the sector.
  svd_sector u_sector (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .prod_vld_i (prod_vld),
    .ua_i       (ua),
    .ub_i       (ub),
    .sec_vld_o  (sec_vld),
    .sec_o      (sec)
  );

  // Build the phase times and apply dead time.
  svd_cmp u_cmp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sec_vld_i    (sec_vld),
    .sec_i        (sec),
    .pwm_period_i (period_q),
    .dead_time_i  (dead_q),
    .done_o       (done_o),
    .sector_o     (sector_o),
    .cmp_a_high_o (cmp_a_high_o),
    .cmp_a_low_o  (cmp_a_low_o),
    .cmp_b_high_o (cmp_b_high_o),
    .cmp_b_low_o  (cmp_b_low_o),
    .cmp_c_high_o (cmp_c_high_o),
    .cmp_c_low_o  (cmp_c_low_o)
  );

  // Every accepted transaction yields exactly one result.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("accepted transaction produced no result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 6))
    else $error("result without an accepted transaction");

endmodule
